// ----- design/kmd_pkg.sv -----
// ----------------------------------------------------------------------------
// Key matrix debounce package
// Shared sizes, types and helper functions for the key matrix debounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmd_pkg;

   // Matrix geometry.
   localparam int ROWS = 8;
   localparam int COLS = 18;

   // Fixed field widths of the request and response items.
   localparam int COL_W       = 5;
   localparam int ROW_FIELD_W = 8;
   localparam int SETTLE_W    = 8;
   localparam int KEY_W       = 8;

   // Packed stream widths (whole bytes).
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd5;
   localparam logic [SETTLE_W-1:0] SETTLE_MIN   = 8'd1;

   localparam int IDX_W   = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int TOTAL_W = $clog2(ROWS * COLS + 1);

   localparam int KEY_LIMIT = 255;
   localparam int KEY_MAX   = (ROWS * COLS > KEY_LIMIT) ? KEY_LIMIT : ROWS * COLS;

   typedef logic [ROWS-1:0]          kmd_row_type;
   typedef kmd_row_type [COLS-1:0]   kmd_matrix_type;
   typedef logic [TOTAL_W-1:0]       kmd_total_type;

   // One column sample as seen by the raw matrix store.
   typedef struct packed {
      logic              wr;
      logic [IDX_W-1:0]  idx;
      kmd_row_type       rows;
   } kmd_sample_type;

   // What the raw matrix store reports back for the current sample.
   typedef struct packed {
      logic          changed;
      kmd_total_type total_next;
   } kmd_raw_status_type;

   // Number of set bits in one column.
   function automatic kmd_total_type ones_in(input kmd_row_type v);
      kmd_total_type n;
      n = '0;
      for (int r = 0; r < ROWS; r++) begin
         n = n + kmd_total_type'(v[r]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- design/key_matrix_debounce_top.sv -----
// ----------------------------------------------------------------------------
// Key matrix debounce top level
// Latency: a response appears in the cycle after its request is accepted.
// Throughput: one request per cycle while rsp_tready is high; the settle and
// publish logic is one pass between request handshake and response register.
// Reset: synchronous; clears both matrices, the counters and the response
// valid flag, and loads settle_scans with 5. No request is taken during reset.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debounce_top
   import kmd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Configuration: settle_scans.
   input  wire logic                  csr_wr_en,
   input  wire logic [SETTLE_W-1:0]   csr_wr_data,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Fields from bit 0: column[4:0], row_bits[12:5], zero padding.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // scan_end.
   input  wire logic                  req_tlast,
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Fields from bit 0: stable_column[7:0], key_count[15:8].
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // settled.
   output logic                       rsp_tuser
);

   // Settle length register. A zero write would never publish, so it is
   // stored as the minimum of one scan.
   logic [SETTLE_W-1:0] settle_scans_ff;

   // Debounce state.
   kmd_matrix_type      stable_ff;
   kmd_matrix_type      stable_in;
   logic [SETTLE_W-1:0] settle_count_ff;
   logic [SETTLE_W-1:0] settle_count_in;
   logic [KEY_W-1:0]    pressed_ff;
   logic [KEY_W-1:0]    pressed_in;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic                  rsp_user_ff;

   // Request decode.
   logic              accept;
   logic [COL_W-1:0]  col;
   logic              col_hit;
   logic [IDX_W-1:0]  col_idx;
   kmd_row_type       rows;
   logic              publish;
   logic [KEY_W-1:0]  column_bits;

   kmd_sample_type     sample;
   kmd_matrix_type     raw_next;
   kmd_raw_status_type raw_status;

   // The response register is the only thing between the two sides, so a new
   // request is taken whenever the held response leaves in the same cycle.
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign col     = req_tdata[COL_W-1:0];
   // Row bits above the matrix height are dropped here.
   assign rows    = req_tdata[COL_W +: ROWS];
   assign col_hit = 32'(col) < 32'(COLS);
   assign col_idx = col_hit ? col[IDX_W-1:0] : '0;

   // A column outside the matrix leaves the raw store alone, but its
   // end-of-scan mark still counts.
   assign sample.wr   = accept && col_hit;
   assign sample.idx  = col_idx;
   assign sample.rows = rows;

   kmd_raw_matrix u_raw (
      .clock    (clock),
      .reset    (reset),
      .sample   (sample),
      .raw_next (raw_next),
      .status   (raw_status)
   );

   // Settle counter. A change reloads it first; an end-of-scan mark in the
   // same request then counts down from the reloaded value.
   always_comb begin
      settle_count_in = settle_count_ff;
      publish         = 1'b0;
      if (accept) begin
         if (raw_status.changed) begin
            settle_count_in = settle_scans_ff;
         end
         if (req_tlast && (settle_count_in != '0)) begin
            settle_count_in = settle_count_in - SETTLE_W'(1);
            publish         = (settle_count_in == '0);
         end
      end
   end

   // Publishing copies the whole raw matrix and takes the running total,
   // which saturates only for matrices larger than the key count field.
   always_comb begin
      stable_in  = stable_ff;
      pressed_in = pressed_ff;
      if (publish) begin
         stable_in = raw_next;
         if (32'(raw_status.total_next) > 32'(KEY_LIMIT)) begin
            pressed_in = KEY_W'(KEY_LIMIT);
         end else begin
            pressed_in = KEY_W'(raw_status.total_next);
         end
      end
   end

   // Response payload reflects the state after this request.
   always_comb begin
      column_bits  = col_hit ? KEY_W'(stable_in[col_idx]) : '0;
      rsp_data_in  = {pressed_in, column_bits};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_scans_ff <= SETTLE_RESET;
      end else if (csr_wr_en) begin
         settle_scans_ff <= (csr_wr_data == '0) ? SETTLE_MIN : csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff       <= '0;
         settle_count_ff <= '0;
         pressed_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         stable_ff       <= stable_in;
         settle_count_ff <= settle_count_in;
         pressed_ff      <= pressed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload needs no reset; it is loaded with every accepted request.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= (settle_count_in == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ----- design/kmd_raw_matrix.sv -----
// ----------------------------------------------------------------------------
// Key matrix debounce raw store
// Holds the raw matrix and a running count of its set bits.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_raw_matrix
   import kmd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire kmd_sample_type     sample,
   output kmd_matrix_type          raw_next,
   output kmd_raw_status_type      status
);

   kmd_matrix_type raw_ff;
   kmd_total_type  total_ff;
   kmd_row_type    old_row;

   always_comb begin
      old_row           = raw_ff[sample.idx];
      raw_next          = raw_ff;
      status.changed    = sample.wr && (old_row != sample.rows);
      status.total_next = total_ff;
      if (status.changed) begin
         raw_next[sample.idx] = sample.rows;
         // The total follows the matrix, so publishing needs no sweep.
         status.total_next    = total_ff - ones_in(old_row) + ones_in(sample.rows);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff   <= '0;
         total_ff <= '0;
      end else begin
         raw_ff   <= raw_next;
         total_ff <= status.total_next;
      end
   end

endmodule

`default_nettype wire

// ----- design/kmd_checker.sv -----
// ----------------------------------------------------------------------------
// Key matrix debounce checker
// Port-level assertions for the key matrix debounce top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_checker
   import kmd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  csr_wr_en,
   input wire logic [SETTLE_W-1:0]   csr_wr_data,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic                  req_tlast,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // The response register never blocks requests while it is empty.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty response register");

   // An accepted request always gives a response in the next cycle.
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no response");

   // The key count never exceeds the number of keys in the matrix.
   a_key_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[15:8]) <= 32'(KEY_MAX))
      else $error("key count out of range");

endmodule

bind key_matrix_debounce_top kmd_checker u_kmd_checker (.*);

`default_nettype wire
